@@ rtl/euclidean_rhythm_sequencer_defines.svh @@
// Assertion macros used by the sequencer port checker.
// No dependencies; include by bare file name.
`ifndef EUCLIDEAN_RHYTHM_SEQUENCER_DEFINES_SVH
`define EUCLIDEAN_RHYTHM_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ERS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ERS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ers_pkg.sv @@
// Shared types, constants and helpers for the Euclidean rhythm sequencer.
// No dependencies; compiled before every other file.
package ers_pkg;

  localparam int MAX_STEPS = 32;
  localparam int CHANNELS  = 4;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int SPB_W    = 20;
  localparam int PAT_W    = 18;
  localparam int FRAMES_W = 13;
  localparam int MASK_W   = 4;
  localparam int POS_W    = 6;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [SPB_W-1:0] SPB_RESET = 20'd24000;

  // remainder unit sizing
  localparam int DIV_NUM_W = SPB_W + 1;
  localparam int DIV_DEN_W = SPB_W;
  localparam int DIV_CNT_W = 5;

  localparam logic [DIV_CNT_W-1:0] SAMP_BITS = DIV_CNT_W'(DIV_NUM_W);
  localparam logic [DIV_CNT_W-1:0] STEP_BITS = DIV_CNT_W'(POS_W + 1);
  localparam logic [DIV_CNT_W-1:0] HIT_BITS  = DIV_CNT_W'(12);

  typedef enum logic [2:0] {
    REG_SPB = 3'd0,
    REG_CH0 = 3'd1,
    REG_CH1 = 3'd2,
    REG_CH2 = 3'd3,
    REG_CH3 = 3'd4
  } ers_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SAMP,
    ST_CH,
    ST_POS,
    ST_ROT,
    ST_MUL,
    ST_HIT,
    ST_DONE
  } ers_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [POS_W-1:0] chan_len(input logic [PAT_W-1:0] pat);
    logic [POS_W-1:0] raw;
    raw = pat[5:0];
    return (raw > POS_W'(MAX_STEPS)) ? POS_W'(MAX_STEPS) : raw;
  endfunction

  function automatic logic [POS_W-1:0] chan_pulses(input logic [PAT_W-1:0] pat);
    return pat[11:6];
  endfunction

  function automatic logic [POS_W-1:0] chan_rot(input logic [PAT_W-1:0] pat);
    return pat[17:12];
  endfunction

endpackage

@@ rtl/ers_in_if.sv @@
// Block input channel: valid/ready plus the audio block word.
// Depends on ers_pkg.
interface ers_in_if;
  import ers_pkg::*;

  logic                valid;
  logic                ready;
  logic [FRAMES_W-1:0] frames_in_block;
  logic                run_request;

  modport source (output valid, frames_in_block, run_request, input ready);
  modport sink   (input valid, frames_in_block, run_request, output ready);
endinterface

@@ rtl/ers_out_if.sv @@
// Result channel: valid/ready plus the trigger word.
// Depends on ers_pkg.
interface ers_out_if;
  import ers_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] fire_mask;
  logic              beat_in_block;
  logic              is_running;

  modport source (output valid, fire_mask, beat_in_block, is_running, input ready);
  modport sink   (input valid, fire_mask, beat_in_block, is_running, output ready);
endinterface

@@ rtl/ers_rem_unit.sv @@
// Shared restoring remainder unit, one quotient bit per cycle.
// Depends on ers_pkg (div_req_t, div_rsp_t).
module ers_rem_unit (
  input  logic             clk,
  input  logic             rst,
  input  ers_pkg::div_req_t req,
  output ers_pkg::div_rsp_t rsp
);
  import ers_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] num_sh;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem, num_sh[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // left-align the numerator so only nbits steps are needed
      num_sh <= req.num << (DIV_CNT_W'(DIV_NUM_W) - req.nbits);
      den    <= req.den;
      rem    <= '0;
      cnt    <= req.nbits;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      rem    <= fits ? DIV_DEN_W'(trial - {1'b0, den}) : DIV_DEN_W'(trial);
      cnt    <= cnt - DIV_CNT_W'(1);
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.rem  = rem;
  end

endmodule

@@ rtl/euclidean_rhythm_sequencer.sv @@
// Four-channel Euclidean rhythm sequencer; one result word per block word.
// The sample wrap and up to three remainders per channel all go through one shared unit.
// A new block word can be accepted in the cycle after the result is loaded into the
// output register. Synchronous reset: stopped, counter and step positions zero, beat
// length 24000.
module euclidean_rhythm_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ers_pkg::ADDR_W-1:0]  paddr,
  input  logic [ers_pkg::DATA_W-1:0]  pwdata,
  output logic [ers_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  ers_in_if.sink                      blocks,
  ers_out_if.source                   results
);
  import ers_pkg::*;

  // configuration
  logic [SPB_W-1:0] spb;
  logic [PAT_W-1:0] chan_reg [CHANNELS];
  logic [2:0]       reg_idx;
  logic [2:0]       ch_off;
  logic [CH_W-1:0]  cfg_ch;
  logic             cfg_wr;

  // running state
  logic             run_flag;
  logic [SPB_W-1:0] sample_count;
  logic [POS_W-1:0] step_pos [CHANNELS];

  // per-item work registers
  ers_state_t          state, state_next;
  logic [CH_W-1:0]     ch;
  logic [FRAMES_W-1:0] frames_q;
  logic                req_q;
  logic                beat_q;
  logic [MASK_W-1:0]   mask_q;
  logic [POS_W-1:0]    s_q;
  logic [POS_W-1:0]    u_q;

  // output register
  logic              out_valid;
  logic [MASK_W-1:0] out_mask;
  logic              out_beat;
  logic              out_run;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [SPB_W-1:0]   spb_eff;
  logic [SPB_W:0]     total;
  logic [PAT_W-1:0]   cur_pat;
  logic [POS_W-1:0]   cur_len;
  logic [POS_W-1:0]   cur_h;
  logic [POS_W-1:0]   rot_m;
  logic [POS_W-1:0]   u_calc;
  logic [11:0]        prod;
  logic [12:0]        m_num;
  logic [POS_W:0]     hit_thresh;
  logic               last_ch;
  logic               need_div;
  logic               hit_direct;
  logic               ch_advance;
  logic               out_load;

  ers_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign ch_off  = reg_idx - 3'(REG_CH0);
  assign cfg_ch  = CH_W'(ch_off);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx) inside
      REG_SPB: prdata = DATA_W'(spb);
      REG_CH0, REG_CH1, REG_CH2, REG_CH3: begin
        if (ch_off < 3'(CHANNELS)) begin
          prdata = DATA_W'(chan_reg[cfg_ch]);
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spb <= SPB_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        chan_reg[c] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx) inside
        REG_SPB: spb <= pwdata[SPB_W-1:0];
        REG_CH0, REG_CH1, REG_CH2, REG_CH3: begin
          if (ch_off < 3'(CHANNELS)) begin
            chan_reg[cfg_ch] <= pwdata[PAT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath helpers ----------------
  assign spb_eff = (spb == '0) ? SPB_W'(1) : spb;
  assign total   = {1'b0, sample_count} + (SPB_W + 1)'(frames_q);
  assign cur_pat = chan_reg[ch];
  assign cur_len = chan_len(cur_pat);
  assign cur_h   = chan_pulses(cur_pat);
  assign last_ch = (ch == CH_W'(CHANNELS - 1));

  assign rot_m  = div_rsp.rem[POS_W-1:0];
  assign u_calc = (s_q >= rot_m) ? (s_q - rot_m) : (s_q + cur_len - rot_m);

  // hit k at unrotated step u: smallest k with 2kL >= 2Hu-H must also satisfy 2kL < 2Hu+H,
  // which reduces to one remainder of (2Hu - H + 2L - 1) by 2L
  assign prod       = {6'b0, cur_h} * {6'b0, u_q};
  assign m_num      = {prod, 1'b0} + {6'b0, cur_len, 1'b0} - {7'b0, cur_h} - 13'd1;
  assign hit_thresh = {cur_len, 1'b0} - {cur_h, 1'b0};
  assign need_div   = (cur_h != '0) && (cur_h < cur_len) && (u_q != '0);
  assign hit_direct = (cur_h != '0) && ((cur_h >= cur_len) || (u_q == '0));

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (blocks.valid) state_next = ST_EVAL;
      ST_EVAL: state_next = req_q ? ST_SAMP : ST_DONE;
      ST_SAMP: if (div_rsp.done) state_next = beat_q ? ST_CH : ST_DONE;
      ST_CH: begin
        if (cur_len != '0) begin
          state_next = ST_POS;
        end else begin
          state_next = last_ch ? ST_DONE : ST_CH;
        end
      end
      ST_POS: if (div_rsp.done) state_next = ST_ROT;
      ST_ROT: if (div_rsp.done) state_next = ST_MUL;
      ST_MUL: begin
        if (need_div) begin
          state_next = ST_HIT;
        end else begin
          state_next = last_ch ? ST_DONE : ST_CH;
        end
      end
      ST_HIT: if (div_rsp.done) state_next = last_ch ? ST_DONE : ST_CH;
      ST_DONE: if (!out_valid || results.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    div_req    = '0;
    ch_advance = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_EVAL: begin
        div_req.start = req_q;
        div_req.num   = DIV_NUM_W'(total);
        div_req.den   = spb_eff;
        div_req.nbits = SAMP_BITS;
      end
      ST_SAMP: ;
      ST_CH: begin
        div_req.start = (cur_len != '0);
        div_req.num   = DIV_NUM_W'({1'b0, step_pos[ch]} + 7'd1);
        div_req.den   = DIV_DEN_W'(cur_len);
        div_req.nbits = STEP_BITS;
        ch_advance    = (cur_len == '0);
      end
      ST_POS: begin
        div_req.start = div_rsp.done;
        div_req.num   = DIV_NUM_W'(chan_rot(cur_pat));
        div_req.den   = DIV_DEN_W'(cur_len);
        div_req.nbits = STEP_BITS;
      end
      ST_ROT: ;
      ST_MUL: begin
        div_req.start = need_div;
        div_req.num   = DIV_NUM_W'(m_num);
        div_req.den   = DIV_DEN_W'({cur_len, 1'b0});
        div_req.nbits = HIT_BITS;
        ch_advance    = !need_div;
      end
      ST_HIT: ch_advance = div_rsp.done;
      ST_DONE: out_load = !out_valid || results.ready;
      default: ;
    endcase
  end

  assign blocks.ready = (state == ST_IDLE);

  // ---------------- control and state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      run_flag     <= 1'b0;
      sample_count <= '0;
      out_valid    <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        step_pos[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_EVAL) begin
        if (req_q) begin
          run_flag <= 1'b1;
        end else if (run_flag) begin
          // stopping: next started block holds a beat
          run_flag     <= 1'b0;
          sample_count <= spb_eff;
        end
      end
      if (state == ST_SAMP && div_rsp.done) begin
        sample_count <= div_rsp.rem;
      end
      if (state == ST_POS && div_rsp.done) begin
        step_pos[ch] <= div_rsp.rem[POS_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- work registers ----------------
  always_ff @(posedge clk) begin
    if (blocks.valid && blocks.ready) begin
      frames_q <= blocks.frames_in_block;
      req_q    <= blocks.run_request;
    end
    if (state == ST_EVAL) begin
      beat_q <= req_q && (total >= {1'b0, spb_eff});
      mask_q <= '0;
      ch     <= '0;
    end
    if (state == ST_POS && div_rsp.done) begin
      s_q <= div_rsp.rem[POS_W-1:0];
    end
    if (state == ST_ROT && div_rsp.done) begin
      u_q <= u_calc;
    end
    if (state == ST_MUL && hit_direct) begin
      mask_q[ch] <= 1'b1;
    end
    if (state == ST_HIT && div_rsp.done && (div_rsp.rem[POS_W:0] >= hit_thresh)) begin
      mask_q[ch] <= 1'b1;
    end
    if (ch_advance && !last_ch) begin
      ch <= ch + CH_W'(1);
    end
    if (out_load) begin
      out_mask <= mask_q;
      out_beat <= beat_q;
      out_run  <= run_flag;
    end
  end

  assign results.valid         = out_valid;
  assign results.fire_mask     = out_mask;
  assign results.beat_in_block = out_beat;
  assign results.is_running    = out_run;

endmodule

@@ rtl/ers_checker.sv @@
// Port-level checks for the rhythm sequencer, bound to the top level.
// Depends on euclidean_rhythm_sequencer_defines.svh and ers_pkg.
`include "euclidean_rhythm_sequencer_defines.svh"

module ers_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        blocks_valid,
  input logic                        blocks_ready,
  input logic                        results_valid,
  input logic                        results_ready,
  input logic [ers_pkg::MASK_W-1:0]  fire_mask,
  input logic                        beat_in_block,
  input logic                        is_running
);
  import ers_pkg::*;

  `ERS_ASSERT_NEXT(a_out_hold, clk, rst, results_valid && !results_ready,
    results_valid && $stable(fire_mask) && $stable(beat_in_block) && $stable(is_running),
    "result word changed while stalled")

  `ERS_ASSERT_SAME(a_no_fire_without_beat, clk, rst, results_valid && !beat_in_block,
    fire_mask == '0, "fire mask set without a step boundary")

  `ERS_ASSERT_SAME(a_beat_when_running, clk, rst, results_valid && beat_in_block,
    is_running, "step boundary reported while stopped")

  `ERS_ASSERT_NEXT(a_busy_after_accept, clk, rst, blocks_valid && blocks_ready,
    !blocks_ready, "block word taken while previous one still in work")

endmodule

bind euclidean_rhythm_sequencer ers_checker u_ers_checker (
  .clk           (clk),
  .rst           (rst),
  .blocks_valid  (blocks.valid),
  .blocks_ready  (blocks.ready),
  .results_valid (results.valid),
  .results_ready (results.ready),
  .fire_mask     (results.fire_mask),
  .beat_in_block (results.beat_in_block),
  .is_running    (results.is_running)
);

@@ bench/ers_trigger_checker.sv @@
// Trigger word checker for the Euclidean rhythm sequencer bench.
// Tracks the register writes, predicts each result word and compares it.
// Depends on ers_pkg, ers_in_if and ers_out_if.
module ers_trigger_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [ers_pkg::ADDR_W-1:0] paddr,
  input  logic [ers_pkg::DATA_W-1:0] pwdata,
  ers_in_if                          blocks,
  ers_out_if                         results,
  output int                         errors,
  output int                         pending
);
  import ers_pkg::*;

  typedef struct packed {
    logic [MASK_W-1:0] fire_mask;
    logic              beat_in_block;
    logic              is_running;
  } trig_word_t;

  trig_word_t trig_expected_q[$];

  logic [SPB_W-1:0] beat_samples;
  logic [PAT_W-1:0] chan_cfg [CHANNELS];
  logic [63:0]      hit_map  [CHANNELS];
  logic [POS_W-1:0] step_at  [CHANNELS];
  logic [SPB_W-1:0] sample_acc;
  logic             running;

  function automatic int unsigned steps_of(input logic [PAT_W-1:0] pat);
    return (pat[5:0] > MAX_STEPS) ? MAX_STEPS : pat[5:0];
  endfunction

  // hit k at floor((2kL+H)/(2H)) + R, mod L
  function automatic logic [63:0] euclid_hits(input logic [PAT_W-1:0] pat);
    int unsigned len, pulses, rot, spot;
    logic [63:0] hits;
    len    = steps_of(pat);
    pulses = pat[11:6];
    rot    = pat[17:12];
    hits   = '0;
    if (len != 0 && pulses != 0) begin
      for (int unsigned k = 0; k < pulses; k++) begin
        spot = ((2 * k * len + pulses) / (2 * pulses) + rot) % len;
        hits[spot] = 1'b1;
      end
    end
    return hits;
  endfunction

  function automatic trig_word_t take_block(input logic [FRAMES_W-1:0] frames,
                                            input logic req);
    trig_word_t  w;
    int unsigned beat_len, total, len;
    w = '0;
    beat_len = (beat_samples == 0) ? 1 : beat_samples;
    if (req) running = 1'b1;
    if (running && !req) begin
      // stopping: arm the counter so the restart block holds a beat
      sample_acc = SPB_W'(beat_len);
      running    = 1'b0;
    end else if (running) begin
      total = sample_acc + frames;
      if (total >= beat_len) begin
        w.beat_in_block = 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
          len = steps_of(chan_cfg[c]);
          if (len != 0) begin
            step_at[c] = POS_W'((step_at[c] + 1) % len);
            if (hit_map[c][step_at[c]]) w.fire_mask[c] = 1'b1;
          end
        end
      end
      sample_acc = SPB_W'(total % beat_len);
    end
    w.is_running = running;
    return w;
  endfunction

  task automatic check_field(input string label, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    trig_word_t want;
    if (rst) begin
      trig_expected_q.delete();
      errors       = 0;
      beat_samples = SPB_RESET;
      sample_acc   = '0;
      running      = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        chan_cfg[c] = '0;
        hit_map[c]  = '0;
        step_at[c]  = '0;
      end
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2]) inside
          REG_SPB: beat_samples = pwdata[SPB_W-1:0];
          REG_CH0, REG_CH1, REG_CH2, REG_CH3: begin
            chan_cfg[paddr[ADDR_W-1:2] - REG_CH0] = pwdata[PAT_W-1:0];
            hit_map[paddr[ADDR_W-1:2] - REG_CH0]  = euclid_hits(pwdata[PAT_W-1:0]);
          end
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        if (trig_expected_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, expected nothing, got %0h/%0b/%0b",
                   $time, results.fire_mask, results.beat_in_block, results.is_running);
        end else begin
          want = trig_expected_q.pop_front();
          check_field("fire_mask", want.fire_mask, results.fire_mask);
          check_field("beat_in_block", want.beat_in_block, results.beat_in_block);
          check_field("is_running", want.is_running, results.is_running);
        end
      end
      if (blocks.valid && blocks.ready)
        trig_expected_q = {trig_expected_q,
                           take_block(blocks.frames_in_block, blocks.run_request)};
    end
    pending = trig_expected_q.size();
  end

endmodule

@@ bench/euclidean_rhythm_sequencer_tb.sv @@
// Top of the Euclidean rhythm sequencer bench: clock, reset, APB writes,
// block word stimulus and result back-pressure; verdict from ers_trigger_checker.
// Depends on ers_pkg, ers_in_if, ers_out_if, the sequencer and the checker.
module euclidean_rhythm_sequencer_tb;
  import ers_pkg::*;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int          trig_errors;
  int          trig_backlog;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_go = 1'b0;

  ers_in_if  blk_ch ();
  ers_out_if trig_ch ();

  euclidean_rhythm_sequencer dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .blocks  (blk_ch),
    .results (trig_ch)
  );

  ers_trigger_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .blocks  (blk_ch),
    .results (trig_ch),
    .errors  (trig_errors),
    .pending (trig_backlog)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #(20 * 1000000);
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : trig_sink
    int unsigned hold_left;
    hold_left = 0;
    trig_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_left = 300;
        hold_go   = 1'b0;
      end
      if (hold_left != 0) begin
        trig_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        trig_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic logic [PAT_W-1:0] euclid_word(input int unsigned len, pulses, rot);
    return {6'(rot), 6'(pulses), 6'(len)};
  endfunction

  // entered and left at a falling edge
  task automatic apb_write(input int unsigned idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // valid stays high after the accept; the next call or drain_blocks decides
  task automatic send_block(input logic [FRAMES_W-1:0] frames, input logic go);
    while ($urandom_range(99) < src_idle_pct) begin
      blk_ch.valid <= 1'b0;
      @(negedge clk);
    end
    blk_ch.valid           <= 1'b1;
    blk_ch.frames_in_block <= frames;
    blk_ch.run_request     <= go;
    @(posedge clk);
    while (!blk_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_blocks();
    blk_ch.valid <= 1'b0;
    while (trig_backlog != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [SPB_W-1:0] spb;
    int unsigned      len;

    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    blk_ch.valid           = 1'b0;
    blk_ch.frames_in_block = '0;
    blk_ch.run_request     = 1'b0;
    src_idle_pct           = 32;
    snk_idle_pct           = 51;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: stop while stopped, then a slow run with no beat
    send_block(100, 1'b0);
    send_block(0, 1'b1);
    send_block(8191, 1'b1);
    send_block(4096, 1'b1);

    // zero beat length, clamped length, pulses over length, rotation past length
    drain_blocks();
    apb_write(REG_SPB, '0);
    apb_write(REG_CH0, euclid_word(8, 3, 0));
    apb_write(REG_CH1, euclid_word(63, 63, 63));
    apb_write(REG_CH2, euclid_word(5, 0, 7));
    apb_write(REG_CH3, euclid_word(0, 5, 0));
    send_block(0, 1'b1);      // counter already past the beat length
    send_block(1, 1'b1);
    send_block(8191, 1'b1);
    send_block(0, 1'b1);
    send_block(3, 1'b1);
    send_block(1, 1'b1);
    send_block(2, 1'b1);
    send_block(5, 1'b0);      // stop
    send_block(0, 1'b0);
    send_block(0, 1'b1);      // restart block holds a beat

    // max beat length; lengths of channels 0 and 1 shrink under the current step positions
    drain_blocks();
    apb_write(REG_SPB, {SPB_W{1'b1}});
    apb_write(REG_CH0, euclid_word(3, 2, 1));
    apb_write(REG_CH1, euclid_word(1, 1, 0));
    apb_write(REG_CH2, euclid_word(32, 32, 31));
    apb_write(REG_CH3, euclid_word(7, 3, 2));
    send_block(8191, 1'b1);
    send_block(4096, 1'b1);
    send_block(1, 1'b0);

    // beat length drops below the armed counter
    drain_blocks();
    apb_write(REG_SPB, 100);
    apb_write(int'(REG_CH3) + 1, $urandom);
    send_block(0, 1'b1);
    send_block(24, 1'b1);
    send_block(1, 1'b1);
    send_block(4095, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain_blocks();
      case (ph / 2)
        0: begin src_idle_pct = 32; snk_idle_pct = 51; end
        1: begin src_idle_pct = 51; snk_idle_pct = 32; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      case ($urandom_range(3))
        0: spb = SPB_W'($urandom_range(1, 64));
        1: spb = SPB_W'($urandom_range(65, 2000));
        2: spb = SPB_W'($urandom_range(0, 3));
        default: spb = SPB_W'($urandom_range(2000, 1048575));
      endcase
      apb_write(REG_SPB, {12'($urandom), spb});
      for (int c = 0; c < CHANNELS; c++) begin
        if ($urandom_range(1)) begin
          apb_write(int'(REG_CH0) + c, $urandom);
        end else begin
          len = $urandom_range(1, MAX_STEPS);
          apb_write(int'(REG_CH0) + c,
                    {14'($urandom), euclid_word(len, $urandom_range(0, len),
                                                $urandom_range(0, len - 1))});
        end
      end
      if ($urandom_range(1))
        apb_write($urandom_range(int'(REG_CH3) + 1, (1 << (ADDR_W - 2)) - 1), $urandom);

      for (int n = 0; n < 125; n++) begin
        if (ph == 0 && n == 40) hold_go = 1'b1;
        if (ph == 3 && n == 60) drain_blocks();
        send_block(($urandom_range(15) == 0) ? FRAMES_W'($urandom_range(0, 8191))
                                             : FRAMES_W'($urandom_range(1, 600)),
                   $urandom_range(99) < 94);
      end
    end

    drain_blocks();
    repeat (160) @(negedge clk);
    if (trig_errors == 0 && trig_backlog == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
